// ----- src/slt_pkg.sv -----
// Shared types and constants for the sorted list table.
package slt_pkg;

  localparam int CAPACITY_DEF = 64;
  localparam int VAL_W        = 32;
  localparam int IN_W         = 40;
  localparam int OUT_W        = 48;

  typedef enum logic [2:0] {
    ACT_INSERT = 3'd0,
    ACT_DELETE = 3'd1,
    ACT_FIND   = 3'd2,
    ACT_CLEAR  = 3'd3,
    ACT_REWIND = 3'd4,
    ACT_NEXT   = 3'd5
  } action_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2,
    ST_END       = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE   = 2'd0,
    S_APPLY  = 2'd1,
    S_SEARCH = 2'd2,
    S_FOUT   = 2'd3
  } state_t;

  // Shift commands broadcast to every cell of the row.
  typedef struct packed {
    logic ins_en;
    logic del_en;
  } cell_ctl_t;

endpackage

// ----- src/slt_cell.sv -----
// One storage cell of the sorted row: holds an entry, compares it and shifts.
module slt_cell
  import slt_pkg::*;
#(
  parameter int CNT_W = 7,
  parameter int INDEX = 0
) (
  input  logic                    clk,
  input  logic                    cmp_en,
  input  logic signed [VAL_W-1:0] cmp_val,
  input  logic signed [VAL_W-1:0] ins_val,
  input  cell_ctl_t               ctl,
  input  logic [CNT_W-1:0]        count,
  input  logic [CNT_W-1:0]        cursor,
  input  logic signed [VAL_W-1:0] left_val,
  input  logic                    left_sh,
  input  logic signed [VAL_W-1:0] right_val,
  output logic signed [VAL_W-1:0] val,
  output logic                    sh,
  output logic                    gt,
  output logic                    eq,
  output logic                    hit,
  output logic [VAL_W-1:0]        rd
);

  localparam logic [CNT_W-1:0] MY_IDX = CNT_W'(INDEX);

  logic signed [VAL_W-1:0] val_r;
  logic                    gt_r;
  logic                    eq_r;
  logic                    valid;
  logic                    ge;

  assign valid = MY_IDX < count;
  // Insert: this cell moves up (or takes the new value) when its entry is
  // larger than the operand, and the first free cell always takes part.
  assign sh    = (valid && gt_r) || (count == MY_IDX);
  assign ge    = valid && (gt_r || eq_r);

  always_ff @(posedge clk) begin
    if (cmp_en) begin
      gt_r <= val_r > cmp_val;
      eq_r <= val_r == cmp_val;
    end
    if (ctl.ins_en && sh) begin
      val_r <= left_sh ? left_val : ins_val;
    end else if (ctl.del_en && ge) begin
      val_r <= right_val;
    end
  end

  assign val = val_r;
  assign gt  = gt_r;
  assign eq  = eq_r;
  assign hit = valid && eq_r;
  assign rd  = (cursor == MY_IDX) ? val_r : '0;

endmodule

// ----- src/sorted_list_table.sv -----
// Sorted list table: a row of compare-and-shift cells with a binary search.
// Insert, delete, clear, rewind and next load the output register from the apply state.
// Find runs the search loop, one probe per cycle, before loading the output register.
// A new input transfer is taken once the previous action has loaded the output register.
// Reset (rst_n low, synchronous) empties the table and rewinds the cursor at once;
// entry storage is not cleared, since entries past the count are never read.
module sorted_list_table
  import slt_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [IN_W-1:0]  in_tdata,   // action[2:0], value[34:3], zero fill
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [OUT_W-1:0] out_tdata   // status[1:0], position[7:2], item[39:8],
                                       // count[46:40], is_full[47]
);

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int IDX_W = $clog2(CAPACITY);
  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);
  localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);
  localparam logic [CNT_W:0]   SRC_ONE = (CNT_W + 1)'(1);

  // Control and search registers.
  state_t                  state_r, state_nxt;
  action_t                 op_r, op_nxt;
  logic signed [VAL_W-1:0] opv_r, opv_nxt;
  logic [CNT_W-1:0]        count_r, count_nxt;
  logic [CNT_W-1:0]        cursor_r, cursor_nxt;
  logic [CNT_W:0]          lo_r, lo_nxt;
  logic [CNT_W:0]          hi_r, hi_nxt;
  status_t                 fstat_r, fstat_nxt;
  logic [IDX_W-1:0]        fpos_r, fpos_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic [OUT_W-1:0]        out_data_r, out_data_nxt;

  // Per-cell signals gathered from the row.
  logic signed [VAL_W-1:0] cell_val [CAPACITY];
  logic [VAL_W-1:0]        cell_rd  [CAPACITY];
  logic [CAPACITY-1:0]     sh_v, gt_v, eq_v, hit_v;

  cell_ctl_t               ctl;
  logic                    accept;
  logic                    slot_free;
  logic                    found;
  logic [VAL_W-1:0]        rd_or;
  logic [CNT_W:0]          mid_sum;
  logic [CNT_W:0]          mid_full;
  logic [IDX_W-1:0]        mid_idx;

  // Result fields assembled before the output register.
  status_t                 res_status;
  logic [IDX_W-1:0]        res_pos;
  logic [VAL_W-1:0]        res_item;
  logic                    res_load;
  logic [IDX_W+5:0]        pos_ext;
  logic [CNT_W+6:0]        cnt_ext;

  assign in_tready  = (state_r == S_IDLE);
  assign accept     = in_tvalid && in_tready;
  assign slot_free  = !out_valid_r || out_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // The row of cells. Each cell compares its entry against the incoming value
  // in the cycle the input transfer happens, so the flags are ready in the next
  // cycle. Inserts shift entries up from the left neighbor, deletes pull them
  // down from the right neighbor.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [VAL_W-1:0] left_val;
    logic                    left_sh;
    logic signed [VAL_W-1:0] right_val;

    if (i == 0) begin : g_first
      assign left_val = '0;
      assign left_sh  = 1'b0;
    end else begin : g_mid
      assign left_val = cell_val[i-1];
      assign left_sh  = sh_v[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_val = '0;
    end else begin : g_inner
      assign right_val = cell_val[i+1];
    end

    slt_cell #(
      .CNT_W (CNT_W),
      .INDEX (i)
    ) u_cell (
      .clk       (clk),
      .cmp_en    (accept),
      .cmp_val   (in_tdata[34:3]),
      .ins_val   (opv_r),
      .ctl       (ctl),
      .count     (count_r),
      .cursor    (cursor_r),
      .left_val  (left_val),
      .left_sh   (left_sh),
      .right_val (right_val),
      .val       (cell_val[i]),
      .sh        (sh_v[i]),
      .gt        (gt_v[i]),
      .eq        (eq_v[i]),
      .hit       (hit_v[i]),
      .rd        (cell_rd[i])
    );
  end

  // Only the cell under the cursor drives a nonzero read word, so an OR of
  // all of them picks out the entry for a next action.
  always_comb begin
    rd_or = '0;
    for (int k = 0; k < CAPACITY; k++) begin
      rd_or = rd_or | cell_rd[k];
    end
  end

  assign found = |hit_v;

  // Floor midpoint of the search window. Both bounds are non-negative
  // whenever the window is open, so an unsigned sum and shift suffice.
  assign mid_sum  = lo_r + hi_r;
  assign mid_full = mid_sum >> 1;
  assign mid_idx  = mid_full[IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      cursor_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      cursor_r    <= cursor_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    opv_r      <= opv_nxt;
    lo_r       <= lo_nxt;
    hi_r       <= hi_nxt;
    fstat_r    <= fstat_nxt;
    fpos_r     <= fpos_nxt;
    out_data_r <= out_data_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    opv_nxt       = opv_r;
    count_nxt     = count_r;
    cursor_nxt    = cursor_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    fstat_nxt     = fstat_r;
    fpos_nxt      = fpos_r;
    ctl           = '0;
    res_status    = ST_OK;
    res_pos       = '0;
    res_item      = '0;
    res_load      = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          op_nxt    = action_t'(in_tdata[2:0]);
          opv_nxt   = in_tdata[34:3];
          state_nxt = S_APPLY;
        end
      end

      S_APPLY: begin
        if (op_r == ACT_FIND) begin
          lo_nxt    = '0;
          hi_nxt    = {1'b0, count_r} - SRC_ONE;
          state_nxt = S_SEARCH;
        end else if (slot_free) begin
          res_load  = 1'b1;
          state_nxt = S_IDLE;
          case (op_r)
            ACT_INSERT: begin
              if (count_r == CAP_CNT) begin
                res_status = ST_FULL;
              end else begin
                ctl.ins_en = 1'b1;
                count_nxt  = count_r + CNT_ONE;
              end
            end
            ACT_DELETE: begin
              if (found) begin
                ctl.del_en = 1'b1;
                count_nxt  = count_r - CNT_ONE;
              end else begin
                res_status = ST_NOT_FOUND;
              end
            end
            ACT_CLEAR: begin
              count_nxt = '0;
            end
            ACT_REWIND: begin
              cursor_nxt = '0;
            end
            ACT_NEXT: begin
              if (cursor_r < count_r) begin
                res_pos    = cursor_r[IDX_W-1:0];
                res_item   = rd_or;
                cursor_nxt = cursor_r + CNT_ONE;
              end else begin
                res_status = ST_END;
              end
            end
            default: begin
            end
          endcase
        end
      end

      S_SEARCH: begin
        // One probe of the binary search per cycle, on the flags registered
        // when the find was accepted.
        if ($signed(lo_r) > $signed(hi_r)) begin
          fstat_nxt = ST_NOT_FOUND;
          fpos_nxt  = '0;
          state_nxt = S_FOUT;
        end else if (eq_v[mid_idx]) begin
          fstat_nxt = ST_OK;
          fpos_nxt  = mid_idx;
          state_nxt = S_FOUT;
        end else if (gt_v[mid_idx]) begin
          hi_nxt = mid_full - SRC_ONE;
        end else begin
          lo_nxt = mid_full + SRC_ONE;
        end
      end

      S_FOUT: begin
        if (slot_free) begin
          res_load   = 1'b1;
          res_status = fstat_r;
          res_pos    = fpos_r;
          state_nxt  = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Position and count are reported in their field widths; wider values
  // are truncated.
  assign pos_ext = {6'b0, res_pos};
  assign cnt_ext = {7'b0, count_nxt};

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (res_load) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = {(count_nxt == CAP_CNT), cnt_ext[6:0], res_item,
                       pos_ext[5:0], res_status};
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

endmodule

// ----- src/slt_checker.sv -----
// Port-level checks for the sorted list table, bound to the top level.
module slt_checker
  import slt_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input logic             clk,
  input logic             rst_n,
  input logic             in_tvalid,
  input logic             in_tready,
  input logic             out_tvalid,
  input logic             out_tready,
  input logic [OUT_W-1:0] out_tdata
);

  localparam logic [6:0] CAP7 = 7'(CAPACITY);

  // A stalled result holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // An accepted action keeps the input closed for at least the next cycle.
  a_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted while busy");

  // A dropped insert can only happen on a full table.
  a_full_drop: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[1:0] == ST_FULL) |-> out_tdata[47])
    else $error("full status without full flag");

  // End of list carries no position and no item.
  a_end_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[1:0] == ST_END) |-> (out_tdata[39:2] == '0))
    else $error("end of list with data");

  // The full flag agrees with the reported count when it fits the field.
  a_full_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (CAPACITY > 127) || (out_tdata[47] == (out_tdata[46:40] == CAP7)))
    else $error("full flag disagrees with count");

endmodule

bind sorted_list_table slt_checker #(.CAPACITY(CAPACITY)) u_slt_checker (.*);

// ----- verif/sorted_list_table_tb.sv -----
// Self-checking testbench for the sorted list table: directed, fill, random and stall traffic.
module sorted_list_table_tb;
  import slt_pkg::*;

  localparam int CAP = CAPACITY_DEF;
  localparam logic [2:0] ACT_NOP6 = 3'd6;
  localparam logic [2:0] ACT_NOP7 = 3'd7;
  localparam int CYCLE_LIMIT = 200000;
  // Long enough to cover the slowest action, a find with its search loop.
  localparam int SETTLE_CYCLES = 24;
  localparam int HOLD_CYCLES = 300;

  // One result transfer, laid out as on out_tdata (status in the lowest bits).
  typedef struct packed {
    logic        is_full;
    logic [6:0]  count;
    logic [31:0] item;
    logic [5:0]  position;
    logic [1:0]  status;
  } table_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_W-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_W-1:0] out_tdata;

  // Predicted contents of the table, kept in step with accepted input transfers.
  logic signed [31:0] tbl_vals [CAP];
  int tbl_count = 0;
  int tbl_cursor = 0;
  table_result_t expected_results [$];

  int fail_cnt = 0;
  int cycle_cnt = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_seq = 0;
  int hold_seen = 0;
  int hold_left = 0;

  sorted_list_table #(.CAPACITY(CAP)) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("sorted_list_table_tb failed");
      $finish;
    end
  end

  // Applies one action to the predicted table and returns the result it should give.
  function automatic table_result_t apply_table_action(input logic [2:0] act,
                                                       input logic signed [31:0] v);
    table_result_t r;
    int at;
    int lo;
    int hi;
    int mid;
    bit found;
    r = '0;
    r.status = ST_OK;
    case (act)
      ACT_INSERT: begin
        if (tbl_count >= CAP) begin
          r.status = ST_FULL;
        end else begin
          // Equal entries stay ahead of the new one.
          at = 0;
          while (at < tbl_count && !(v < tbl_vals[at])) at++;
          for (int i = tbl_count; i > at; i--) tbl_vals[i] = tbl_vals[i-1];
          tbl_vals[at] = v;
          tbl_count++;
        end
      end
      ACT_DELETE: begin
        at = 0;
        while (at < tbl_count && tbl_vals[at] != v) at++;
        if (at >= tbl_count) begin
          r.status = ST_NOT_FOUND;
        end else begin
          for (int i = at; i + 1 < tbl_count; i++) tbl_vals[i] = tbl_vals[i+1];
          tbl_count--;
        end
      end
      ACT_FIND: begin
        // Floor-midpoint search; the first equal entry it lands on wins.
        lo = 0;
        hi = tbl_count - 1;
        found = 1'b0;
        while (!found && lo <= hi) begin
          mid = (lo + hi) / 2;
          if (v == tbl_vals[mid]) begin
            r.position = 6'(mid);
            found = 1'b1;
          end else if (v < tbl_vals[mid]) begin
            hi = mid - 1;
          end else begin
            lo = mid + 1;
          end
        end
        if (!found) r.status = ST_NOT_FOUND;
      end
      ACT_CLEAR: tbl_count = 0;
      ACT_REWIND: tbl_cursor = 0;
      ACT_NEXT: begin
        if (tbl_cursor < tbl_count) begin
          r.position = 6'(tbl_cursor);
          r.item = tbl_vals[tbl_cursor];
          tbl_cursor++;
        end else begin
          r.status = ST_END;
        end
      end
      default: ;
    endcase
    r.count = 7'(tbl_count);
    r.is_full = (tbl_count == CAP);
    return r;
  endfunction

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0h, actual %0h", name, want, got);
      fail_cnt++;
    end
  endtask

  // Result checker and input monitor, both sampled at the rising edge.
  always @(posedge clk) begin
    table_result_t got;
    table_result_t want;
    if (rst_n) begin
      if (out_tvalid === 1'b1 && out_tready) begin
        got = out_tdata;
        if (expected_results.size() == 0) begin
          $error("result transfer with no expected result: %0h", out_tdata);
          fail_cnt++;
        end else begin
          want = expected_results.pop_front();
          compare_field("status", 32'(want.status), 32'(got.status));
          compare_field("position", 32'(want.position), 32'(got.position));
          compare_field("item", want.item, got.item);
          compare_field("count", 32'(want.count), 32'(got.count));
          compare_field("is_full", 32'(want.is_full), 32'(got.is_full));
        end
      end
      if (in_tvalid && in_tready === 1'b1)
        expected_results.push_back(apply_table_action(in_tdata[2:0], in_tdata[34:3]));
    end
  end

  // Receiver: random stalls, plus a long hold-off whenever a test requests one.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_seq != hold_seen) begin
      hold_seen <= hold_seq;
      hold_left <= HOLD_CYCLES;
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= (recv_idle_pct == 0) || ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Offers one item and returns at the falling edge after its transfer.
  task automatic send_op(input logic [2:0] act, input logic [31:0] val);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {5'b0, val, act};
    do @(posedge clk); while (in_tready !== 1'b1);
    @(negedge clk);
  endtask

  task automatic wait_drained;
    in_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Mostly small values so that duplicates, hits and misses are all common.
  function automatic logic [31:0] pick_value;
    logic [31:0] v;
    int k;
    k = $urandom_range(99);
    if (k < 45) begin
      v = $urandom_range(16);
      v = v - 32'd8;
    end else if (k < 70 && tbl_count > 0) begin
      v = tbl_vals[$urandom_range(tbl_count - 1)];
    end else if (k < 80) begin
      case ($urandom_range(3))
        0: v = 32'h7FFF_FFFF;
        1: v = 32'h8000_0000;
        2: v = 32'h7FFF_FFFE;
        default: v = 32'h8000_0001;
      endcase
    end else begin
      v = $urandom();
    end
    return v;
  endfunction

  task automatic test_directed;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    send_op(ACT_NEXT, 32'd0);           // empty table reads past the end
    send_op(ACT_FIND, 32'd0);           // absent find
    send_op(ACT_DELETE, 32'd0);         // absent delete
    send_op(ACT_INSERT, 32'h7FFF_FFFF);
    send_op(ACT_INSERT, 32'h8000_0000);
    send_op(ACT_INSERT, 32'd0);
    send_op(ACT_INSERT, 32'd5);
    send_op(ACT_INSERT, 32'd5);
    send_op(ACT_INSERT, 32'hFFFF_FFFF);
    send_op(ACT_FIND, 32'd5);
    send_op(ACT_FIND, 32'h7FFF_FFFF);
    send_op(ACT_FIND, 32'h8000_0000);
    send_op(ACT_FIND, 32'd3);
    send_op(ACT_REWIND, 32'hFFFF_FFFF);
    send_op(ACT_NEXT, 32'hFFFF_FFFF);
    send_op(ACT_NEXT, 32'd0);
    send_op(ACT_DELETE, 32'd5);
    send_op(ACT_DELETE, 32'd12345);
    send_op(ACT_NEXT, 32'd0);           // cursor is left where it was by the delete
    send_op(ACT_NOP6, 32'hA5A5_5A5A);
    send_op(ACT_NOP7, 32'h5A5A_A5A5);
    send_op(ACT_CLEAR, 32'd0);
    send_op(ACT_NEXT, 32'd0);           // cursor now beyond the count
    send_op(ACT_REWIND, 32'd0);
    send_op(ACT_NEXT, 32'd0);
    wait_drained();
  endtask

  // Fills the table, pushes inserts into a full table, runs finds, reads it all back, then deletes and inserts.
  task automatic test_fill_to_capacity;
    send_op(ACT_CLEAR, $urandom());
    send_op(ACT_REWIND, $urandom());
    for (int i = 0; i < CAP; i++) send_op(ACT_INSERT, pick_value());
    for (int i = 0; i < 4; i++) send_op(ACT_INSERT, pick_value());
    for (int i = 0; i < 12; i++) send_op(ACT_FIND, pick_value());
    for (int i = 0; i < CAP + 2; i++) send_op(ACT_NEXT, $urandom());
    for (int i = 0; i < 8; i++) send_op(ACT_DELETE, pick_value());
    for (int i = 0; i < 8; i++) send_op(ACT_INSERT, pick_value());
    wait_drained();
  endtask

  task automatic test_random_traffic(input int n_items, input int snd_idle,
                                     input int rcv_idle);
    int sent;
    int k;
    int ins_share;
    sent = 0;
    send_idle_pct = snd_idle;
    recv_idle_pct = rcv_idle;
    while (sent < n_items) begin
      k = $urandom_range(99);
      ins_share = (tbl_count > CAP - 8) ? 20 : 40;
      if (k < 3) begin
        // Full in-order sweep that runs one step past the end.
        send_op(ACT_REWIND, $urandom());
        for (int i = 0; i <= tbl_count; i++) send_op(ACT_NEXT, $urandom());
        sent += tbl_count + 2;
      end else begin
        k = $urandom_range(99);
        if (k < ins_share) send_op(ACT_INSERT, pick_value());
        else if (k < 60) send_op(ACT_DELETE, pick_value());
        else if (k < 78) send_op(ACT_FIND, pick_value());
        else if (k < 92) send_op(ACT_NEXT, $urandom());
        else if (k < 95) send_op(ACT_REWIND, $urandom());
        else if (k < 97) send_op(ACT_CLEAR, $urandom());
        else if (k < 98) send_op(ACT_NOP6, $urandom());
        else send_op(ACT_NOP7, $urandom());
        sent++;
      end
    end
    wait_drained();
  endtask

  // The receiver holds off while items keep coming, so the input side must stall.
  task automatic test_output_stall;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_seq <= hold_seq + 1;
    for (int i = 0; i < 40; i++) begin
      if (i % 4 == 0) send_op(ACT_FIND, pick_value());
      else if (i % 4 == 1) send_op(ACT_NEXT, $urandom());
      else send_op(ACT_INSERT, pick_value());
    end
    wait_drained();
  endtask

  initial begin
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_directed();
    test_fill_to_capacity();
    test_random_traffic(280, 27, 52);
    test_random_traffic(280, 52, 27);
    test_random_traffic(280, 0, 0);
    test_output_stall();
    if (fail_cnt == 0) begin
      $display("sorted_list_table_tb passed");
    end else begin
      $display("sorted_list_table_tb failed");
    end
    $finish;
  end

endmodule
